/* hdl/timer_table_scheduler_core_macros.svh */
// Assertion macros for the timer table scheduler.
`ifndef TIMER_TABLE_SCHEDULER_CORE_MACROS_SVH
`define TIMER_TABLE_SCHEDULER_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define TTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* hdl/tts_pkg.sv */
// Package: types, codes and sizes for the timer table scheduler.
package tts_pkg;
  localparam int unsigned NumTimersDef = 16;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

  localparam logic [2:0] FuncStart   = 3'd0;
  localparam logic [2:0] FuncDelete  = 3'd1;
  localparam logic [2:0] FuncSetPer  = 3'd2;
  localparam logic [2:0] FuncSetRep  = 3'd3;
  localparam logic [2:0] FuncService = 3'd4;
  localparam logic [2:0] FuncRead    = 3'd5;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatNoHandle = 2'd1;
  localparam logic [1:0] StatInactive = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  slot;
    logic [31:0] period_ms;
    logic [31:0] repeat_count;
    logic        handler_present;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        fired;
    logic [3:0]  fired_slot;
    logic        nothing_pending;
    logic [30:0] wait_ms;
    logic [31:0] read_period;
    logic [31:0] read_repeat;
  } out_word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture input word
    logic clr_best;   // start a scan
    logic rd_issue;   // issue read of scan index (or addressed slot)
    logic use_scan;   // read address from scan counter
    logic scan_eval;  // evaluate returned scan entry
    logic scan_inc;
    logic finish;     // compute and register result
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic is_service;
  } stat_t;
endpackage

/* hdl/tts_if.sv */
// Valid/ready channel interface carrying one word.
interface tts_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/timer_table_scheduler_core.sv */
// Top level of the timer table scheduler: channels, controller and datapath.
//  channel  | dir | word
//  cmd_in   | in  | func, slot, period_ms, repeat_count, handler_present, now_ms
//  rsp_out  | out | status, fired, fired_slot, nothing_pending, wait_ms, read_*
// One command at a time. A non-service command passes through accept, read,
// wait and finish; service passes through accept, a scan of the slot RAMs at
// one slot per cycle, wait and finish.
// A result waits in an output register; finish stalls while it is still held.
// Reset clears all slots to inactive; period, repeat and deadline RAMs are
// not cleared since start always writes them first.
`include "timer_table_scheduler_core_macros.svh"
module timer_table_scheduler_core import tts_pkg::*; #(
  parameter int unsigned NUM_TIMERS = NumTimersDef
) (
  input logic clk_i,
  input logic rst_ni,
  tts_if.sink   cmd_in,
  tts_if.source rsp_out
);
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  tts_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (cmd_in.valid),
    .in_ready_o (in_ready),
    .out_valid_o(rsp_out.valid),
    .out_ready_i(rsp_out.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );
  assign cmd_in.ready = in_ready;

  tts_dp #(.NumTimers(NUM_TIMERS)) u_dp (
    .clk_i, .rst_ni,
    .in_i  (cmd_in.data),
    .cmd_i (cmd),
    .stat_o(stat),
    .out_o (rsp_out.data)
  );

  // Fired and nothing-pending never appear together.
  `TTS_ASSERT_IMP(a_excl, clk_i, rst_ni, rsp_out.valid,
    !(rsp_out.data.fired && rsp_out.data.nothing_pending), "fired with nothing pending")
  // No new command while the previous one is in flight.
  `TTS_ASSERT_NEXT(a_busy, clk_i, rst_ni, cmd_in.valid && cmd_in.ready, !cmd_in.ready,
    "accepted back to back")
  // A result holds while stalled.
  `TTS_ASSERT_NEXT(a_hold, clk_i, rst_ni, rsp_out.valid && !rsp_out.ready,
    rsp_out.valid && $stable(rsp_out.data), "result dropped")
endmodule

/* hdl/tts_ram.sv */
// Generic RAM with one write port and one registered read port.
module tts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

/* hdl/tts_ctrl.sv */
// Controller state machine for the timer table scheduler.
module tts_ctrl import tts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRead = 3'd1;
  localparam logic [2:0] SScan = 3'd2;
  localparam logic [2:0] SWait = 3'd3;
  localparam logic [2:0] SDone = 3'd4;

  logic [2:0] state_q, state_d;
  logic       ov_q, ov_d;
  logic       scan_v_q, scan_v_d;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d  = state_q;
    ov_d     = ov_q && !out_ready_i;
    scan_v_d = 1'b0;
    cmd_o    = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SRead;
        end
      end
      SRead: begin
        cmd_o.clr_best = 1'b1;
        cmd_o.rd_issue = 1'b1;
        if (stat_i.is_service) begin
          cmd_o.use_scan = 1'b1;
          cmd_o.scan_inc = 1'b1;
          scan_v_d       = 1'b1;
          state_d        = stat_i.scan_last ? SWait : SScan;
        end else begin
          state_d = SWait;
        end
      end
      SScan: begin
        cmd_o.rd_issue  = 1'b1;
        cmd_o.use_scan  = 1'b1;
        cmd_o.scan_inc  = 1'b1;
        cmd_o.scan_eval = scan_v_q;
        scan_v_d        = 1'b1;
        if (stat_i.scan_last) state_d = SWait;
      end
      SWait: begin
        cmd_o.scan_eval = scan_v_q && stat_i.is_service;
        state_d         = SDone;
      end
      SDone: begin
        if (!ov_q) begin
          cmd_o.finish = 1'b1;
          ov_d         = 1'b1;
          state_d      = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      ov_q     <= 1'b0;
      scan_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ov_q     <= ov_d;
      scan_v_q <= scan_v_d;
    end
  end
endmodule

/* hdl/tts_dp.sv */
// Datapath: slot tables, scan for earliest deadline, result formation.
module tts_dp import tts_pkg::*; #(
  parameter int unsigned NumTimers = NumTimersDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_i,
  input  cmd_t      cmd_i,
  output stat_t     stat_o,
  output out_word_t out_o
);
  localparam int unsigned Aw = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int unsigned Dp = 1 << Aw;

  in_word_t          it_q;
  logic [Dp-1:0]     act_q;
  logic [Aw-1:0]     scan_q, idx_q;
  logic [Aw-1:0]     raddr;
  logic [31:0]       per_r, rep_r, dl_r;
  logic              best_v_q;
  logic [Aw-1:0]     best_q;
  logic [31:0]       best_dl_q, best_per_q, best_rep_q;
  logic [Dp-1:0]     free_q;
  out_word_t         out_q;
  logic              in_tab;
  logic [Aw-1:0]     sidx;
  logic              live;

  assign sidx   = Aw'(it_q.slot);
  assign in_tab = ({28'd0, it_q.slot} < 32'(NumTimers));
  assign live   = in_tab && act_q[sidx];
  assign raddr  = cmd_i.use_scan ? scan_q : sidx;
  assign stat_o.scan_last  = (32'(scan_q) == 32'(NumTimers - 1));
  assign stat_o.is_service = (it_q.func == FuncService);

  // Write port decisions, made at finish.
  logic           we;
  logic [Aw-1:0]  wa;
  logic [31:0]    wper, wrep, wdl;
  logic           wr_per, wr_rep, wr_dl;
  logic [31:0]    nrep, dwait;
  out_word_t      res;
  logic           due;

  assign nrep  = (it_q.repeat_count == 32'd0) ? AllOnes : it_q.repeat_count;
  assign dwait = best_dl_q - it_q.now_ms;
  assign due   = !((dwait != 32'd0) && !dwait[31]);

  always_comb begin
    res = '0; we = 1'b0; wa = sidx;
    wper = it_q.period_ms; wrep = nrep; wdl = it_q.now_ms + it_q.period_ms;
    wr_per = 1'b0; wr_rep = 1'b0; wr_dl = 1'b0;
    case (it_q.func)
      FuncStart: begin
        if (!it_q.handler_present && it_q.period_ms != AllOnes) res.status = StatNoHandle;
        else if (!in_tab) res.status = StatInactive;
        else begin
          we = 1'b1; wr_per = 1'b1; wr_rep = 1'b1; wr_dl = 1'b1;
        end
      end
      FuncDelete: if (!live) res.status = StatInactive;
      FuncSetPer: begin
        if (live) begin
          we = 1'b1; wr_per = 1'b1; wr_dl = 1'b1;
        end else res.status = StatInactive;
      end
      FuncSetRep: begin
        if (live) begin
          we = 1'b1; wr_rep = 1'b1;
        end else res.status = StatInactive;
      end
      FuncService: begin
        wa = best_q;
        if (!best_v_q) res.nothing_pending = 1'b1;
        else if (!due) res.wait_ms = dwait[30:0];
        else begin
          res.fired      = 1'b1;
          res.fired_slot = 4'(best_q);
          we = 1'b1; wr_rep = 1'b1; wr_dl = 1'b1;
          wrep = (best_rep_q != AllOnes) ? best_rep_q - 32'd1 : best_rep_q;
          wdl  = it_q.now_ms + best_per_q;
        end
      end
      FuncRead: begin
        if (live) begin
          res.read_period = per_r;
          res.read_repeat = rep_r;
        end else begin
          res.status      = StatInactive;
          res.read_period = AllOnes;
        end
      end
      default: ;
    endcase
  end

  tts_ram #(.Width(32), .Depth(Dp)) u_per (.clk_i, .we_i(cmd_i.finish && we && wr_per),
    .waddr_i(wa), .wdata_i(wper), .raddr_i(raddr), .rdata_o(per_r));
  tts_ram #(.Width(32), .Depth(Dp)) u_rep (.clk_i, .we_i(cmd_i.finish && we && wr_rep),
    .waddr_i(wa), .wdata_i(wrep), .raddr_i(raddr), .rdata_o(rep_r));
  tts_ram #(.Width(32), .Depth(Dp)) u_dl (.clk_i, .we_i(cmd_i.finish && we && wr_dl),
    .waddr_i(wa), .wdata_i(wdl), .raddr_i(raddr), .rdata_o(dl_r));

  logic cand, better;
  logic [31:0] ddiff;
  assign ddiff  = dl_r - best_dl_q;
  assign cand   = act_q[idx_q] && (rep_r != 32'd0) && (per_r != AllOnes);
  assign better = !best_v_q || ddiff[31];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= in_i;
    if (cmd_i.rd_issue) idx_q <= raddr;
    if (cmd_i.scan_eval && cand && better) begin
      best_q     <= idx_q;
      best_dl_q  <= dl_r;
      best_per_q <= per_r;
      best_rep_q <= rep_r;
    end
    if (cmd_i.finish) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= '0;
      scan_q   <= '0;
      best_v_q <= 1'b0;
      free_q   <= '0;
    end else begin
      if (cmd_i.clr_best) begin
        best_v_q <= 1'b0;
        free_q   <= '0;
      end
      // Wraps to zero after the last slot, ready for the next scan.
      if (cmd_i.scan_inc) scan_q <= stat_o.scan_last ? '0 : scan_q + Aw'(1);
      if (cmd_i.scan_eval && act_q[idx_q] && rep_r == 32'd0) free_q[idx_q] <= 1'b1;
      if (cmd_i.scan_eval && cand && better) best_v_q <= 1'b1;
      if (cmd_i.finish) begin
        if (it_q.func == FuncService) act_q <= act_q & ~free_q;
        else if (it_q.func == FuncStart && we) act_q[sidx] <= 1'b1;
        else if (it_q.func == FuncDelete && live) act_q[sidx] <= 1'b0;
      end
    end
  end

  assign out_o = out_q;
endmodule

/* tb/timer_table_scheduler_checker.sv */
// Checker: predicts timer table results from accepted command words and compares.
module timer_table_scheduler_checker import tts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_fire_i,
  input  in_word_t  cmd_word_i,
  input  logic      rsp_fire_i,
  input  out_word_t rsp_word_i,
  output int        errors_o,
  output int        pending_o
);
  logic        act_q [16];
  logic [31:0] per_q [16];
  logic [31:0] rep_q [16];
  logic [31:0] dl_q  [16];
  out_word_t   expected_rsp [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors_o++;
  endtask

  function automatic out_word_t predict_timer(input in_word_t w);
    out_word_t   o;
    int          best;
    logic [31:0] d;
    logic        live;
    o = '0;
    best = -1;
    live = act_q[w.slot];
    case (w.func)
      FuncStart: begin
        if (!w.handler_present && w.period_ms != AllOnes) begin
          o.status = StatNoHandle;
        end else begin
          act_q[w.slot] = 1'b1;
          per_q[w.slot] = w.period_ms;
          rep_q[w.slot] = (w.repeat_count == 0) ? AllOnes : w.repeat_count;
          dl_q[w.slot]  = w.now_ms + w.period_ms;
        end
      end
      FuncDelete: if (live) act_q[w.slot] = 1'b0; else o.status = StatInactive;
      FuncSetPer: begin
        if (live) begin
          per_q[w.slot] = w.period_ms;
          dl_q[w.slot]  = w.now_ms + w.period_ms;
        end else o.status = StatInactive;
      end
      FuncSetRep: begin
        if (live) rep_q[w.slot] = (w.repeat_count == 0) ? AllOnes : w.repeat_count;
        else o.status = StatInactive;
      end
      FuncService: begin
        for (int i = 0; i < 16; i++) begin
          if (act_q[i]) begin
            if (rep_q[i] == 0) act_q[i] = 1'b0;
            else if (per_q[i] != AllOnes) begin
              if (best < 0) best = i;
              else begin
                d = dl_q[i] - dl_q[best];
                if (d[31]) best = i;
              end
            end
          end
        end
        if (best < 0) o.nothing_pending = 1'b1;
        else begin
          d = dl_q[best] - w.now_ms;
          if (d != 0 && !d[31]) o.wait_ms = d[30:0];
          else begin
            if (rep_q[best] != AllOnes) rep_q[best] = rep_q[best] - 1;
            dl_q[best] = w.now_ms + per_q[best];
            o.fired = 1'b1;
            o.fired_slot = best[3:0];
          end
        end
      end
      FuncRead: begin
        if (live) begin
          o.read_period = per_q[w.slot];
          o.read_repeat = rep_q[w.slot];
        end else begin
          o.status = StatInactive;
          o.read_period = AllOnes;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    if (!rst_ni) begin
      errors_o = 0;
      for (int i = 0; i < 16; i++) act_q[i] = 1'b0;
      expected_rsp.delete();
    end else begin
      if (cmd_fire_i) expected_rsp.push_back(predict_timer(cmd_word_i));
      if (rsp_fire_i) begin
        if (expected_rsp.size() == 0) begin
          $display("unexpected response word");
          errors_o++;
        end else begin
          e = expected_rsp.pop_front();
          if (rsp_word_i.status != e.status)
            report_mismatch("status", rsp_word_i.status, e.status);
          if (rsp_word_i.fired != e.fired)
            report_mismatch("fired", rsp_word_i.fired, e.fired);
          if (rsp_word_i.fired_slot != e.fired_slot)
            report_mismatch("fired_slot", rsp_word_i.fired_slot, e.fired_slot);
          if (rsp_word_i.nothing_pending != e.nothing_pending)
            report_mismatch("nothing_pending", rsp_word_i.nothing_pending,
                            e.nothing_pending);
          if (rsp_word_i.wait_ms != e.wait_ms)
            report_mismatch("wait_ms", rsp_word_i.wait_ms, e.wait_ms);
          if (rsp_word_i.read_period != e.read_period)
            report_mismatch("read_period", rsp_word_i.read_period, e.read_period);
          if (rsp_word_i.read_repeat != e.read_repeat)
            report_mismatch("read_repeat", rsp_word_i.read_repeat, e.read_repeat);
        end
      end
    end
    pending_o = expected_rsp.size();
  end
endmodule

/* tb/timer_table_scheduler_core_tb.sv */
// Testbench top: drives timer commands, random stalls, and gives the verdict.
module timer_table_scheduler_core_tb import tts_pkg::*;;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors, pending, cycles;
  logic long_stall = 1'b0;
  logic stall_done = 1'b0;
  logic [31:0] now_q = 32'd100;

  tts_if #(.T(in_word_t))  cmd_ch ();
  tts_if #(.T(out_word_t)) rsp_ch ();

  timer_table_scheduler_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_in(cmd_ch.sink), .rsp_out(rsp_ch.source)
  );

  timer_table_scheduler_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cmd_fire_i(cmd_ch.valid && cmd_ch.ready), .cmd_word_i(cmd_ch.data),
    .rsp_fire_i(rsp_ch.valid && rsp_ch.ready), .rsp_word_i(rsp_ch.data),
    .errors_o(errors), .pending_o(pending)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog: fails an overrunning run, allowing for service scans, random stalls on each side and the long hold.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random ready gaps, one long hold-off after the first 200 words.
  initial begin
    int gap, taken;
    rsp_ch.ready = 1'b0;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      gap = (taken > 400 && taken < 480) ? 0 : $urandom_range(0, 4);
      if (taken == 200 && !stall_done) begin
        long_stall = 1'b1;
        repeat (300) @(posedge clk_i);
        long_stall = 1'b0;
        stall_done = 1'b1;
      end
      repeat (gap) @(posedge clk_i);
      rsp_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_ch.valid) @(posedge clk_i);
      taken++;
      rsp_ch.ready <= 1'b0;
    end
  end

  // Send one command word and hold it until accepted; the time comes from the caller.
  task automatic send_word(input logic [2:0] f, input logic [3:0] s,
                           input logic [31:0] per, input logic [31:0] rep,
                           input logic hp, input logic [31:0] now);
    in_word_t w;
    w.func = f; w.slot = s; w.period_ms = per; w.repeat_count = rep;
    w.handler_present = hp; w.now_ms = now;
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= w;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_period();
    case ($urandom_range(0, 9))
      0: return AllOnes;
      1: return 32'd0;
      2: return $urandom;
      3: return 32'h8000_0000 + $urandom_range(0, 3);
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  function automatic logic [31:0] pick_repeat();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom;
      2: return AllOnes;
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  initial begin
    int f;
    logic [3:0] s;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, inactive slots, rejected and suspended starts.
    send_word(FuncService, 0, 0, 0, 0, now_q);
    send_word(FuncRead, 4'd15, 0, 0, 0, now_q);
    send_word(FuncDelete, 4'd3, 0, 0, 1, now_q);
    send_word(FuncSetPer, 4'd3, 5, 0, 1, now_q);
    send_word(FuncSetRep, 4'd3, 0, 5, 1, now_q);
    send_word(FuncStart, 4'd0, 32'd10, 32'd0, 1'b0, now_q);
    send_word(FuncStart, 4'd0, AllOnes, 32'd2, 1'b0, now_q);
    send_word(FuncRead, 4'd0, 0, 0, 0, now_q);
    send_word(FuncService, 0, 0, 0, 0, now_q);
    send_word(FuncStart, 4'd15, 32'd10, 32'd0, 1'b1, now_q);
    send_word(FuncStart, 4'd7, 32'd10, 32'd2, 1'b1, now_q);
    send_word(FuncStart, 4'd7, 32'd10, 32'd2, 1'b1, now_q);
    send_word(FuncService, 0, 0, 0, 0, now_q);
    send_word(FuncService, 0, 0, 0, 0, now_q + 10);
    send_word(FuncService, 0, 0, 0, 0, now_q + 20);
    send_word(FuncService, 0, 0, 0, 0, now_q + 40);
    send_word(FuncRead, 4'd7, 0, 0, 0, now_q);
    send_word(FuncSetPer, 4'd15, 32'hFFFF_FFFE, 0, 1, 32'hFFFF_FFFF);
    send_word(FuncSetRep, 4'd15, 0, 32'hFFFF_FFFF, 1, now_q);
    send_word(FuncRead, 4'd15, 0, 0, 0, now_q);
    send_word(FuncService, 0, 0, 0, 0, 32'h8000_0000);
    send_word(3'd6, 4'd1, AllOnes, AllOnes, 1, AllOnes);
    send_word(3'd7, 4'd2, 0, 0, 0, 0);
    send_word(FuncDelete, 4'd15, 0, 0, 1, now_q);

    // Random: mostly live timers serviced at advancing time.
    for (int n = 0; n < 700; n++) begin
      if (n == 350) begin
        // Drain pause: hold off until every result is back.
        cmd_ch.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      if (!long_stall && n % 40 > 30) idle_gap($urandom_range(0, 4));
      now_q = ($urandom_range(0, 49) == 0) ? $urandom : now_q + $urandom_range(0, 12);
      f = $urandom_range(0, 11);
      s = 4'($urandom_range(0, 15));
      case (f)
        0, 1: send_word(FuncStart, s, pick_period(), pick_repeat(),
                        $urandom_range(0, 7) != 0, now_q);
        2: send_word(FuncDelete, s, $urandom, $urandom, 1'($urandom), now_q);
        3: send_word(FuncSetPer, s, pick_period(), $urandom, 1'($urandom), now_q);
        4: send_word(FuncSetRep, s, $urandom, pick_repeat(), 1'($urandom), now_q);
        5: send_word(FuncRead, s, $urandom, $urandom, 1'($urandom), now_q);
        6: send_word(3'($urandom_range(6, 7)), s, $urandom, $urandom, 1'($urandom),
                     now_q);
        default: send_word(FuncService, s, $urandom, $urandom, 1'($urandom), now_q);
      endcase
    end
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
